// ----- design/spq_pkg.sv -----
// shared types and constants of the stable priority queue
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_BITS = 16;
   localparam int KEY_BITS = 8;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_BITS = 5;
   localparam int STATUS_BITS = 2;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type fresh;
   } cell_ctl_type;

   typedef struct packed {
      logic                req_type;
      logic [ID_BITS-1:0]  entry_id;
      logic [KEY_BITS-1:0] entry_key;
   } req_word_type;

   typedef struct packed {
      logic                   popped_valid;
      logic [ID_BITS-1:0]     popped_id;
      logic [KEY_BITS-1:0]    popped_key;
      logic [OCC_BITS-1:0]    occupancy;
      logic [STATUS_BITS-1:0] status;
   } rsp_word_type;

endpackage

// ----- design/spq_if.sv -----
// request and response channel interfaces
interface spq_req_if;
   logic                  valid;
   logic                  ready;
   spq_pkg::req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface spq_rsp_if;
   logic                  valid;
   logic                  ready;
   spq_pkg::rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- design/spq_cell.sv -----
// one slot of the sorted chain: holds an entry and shifts with its neighbors
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctl_type ctl,
   input  logic                  occ,
   input  logic                  left_stay,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output spq_pkg::entry_type    entry,
   output logic                  stay
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   assign entry = entry_ff;
   assign stay  = occ && (entry_ff.key <= ctl.fresh.key);

   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (stay) begin
            entry_in = entry_ff;
         end else if (left_stay) begin
            entry_in = ctl.fresh;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- design/stable_priority_queue.sv -----
// stable priority queue: sorted chain of slots, lowest key leaves first
//
// usage:
// - req_if carries one word per request: req_type selects insert or pop,
//   entry_id and entry_key give the entry to insert (ignored on pop)
// - rsp_if returns exactly one word per request: the popped entry on a
//   successful pop, the occupancy after the request and a status code
// - equal keys leave in arrival order
// - an insert into a full queue is dropped with status full, a pop on an
//   empty queue returns status empty and leaves the queue as it was
// - the response word appears in the cycle after the request is taken
// - throughput is one request per cycle while the receiver keeps up: every
//   slot compares its key with the new key and shifts one place in the same cycle
// - the response sits in an output register; while the receiver stalls,
//   req_if.ready is low and the queue holds, and the next request is taken
//   in the same cycle the waiting word is taken
// - reset empties the queue and drops any waiting response word
module stable_priority_queue (
   input logic      clock,
   input logic      reset,
   spq_req_if.sink  req_if,
   spq_rsp_if.source rsp_if
);

   logic [spq_pkg::CNT_BITS-1:0] count_ff;
   logic [spq_pkg::CNT_BITS-1:0] count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   spq_pkg::rsp_word_type        rsp_word_ff;
   spq_pkg::rsp_word_type        rsp_word_in;

   spq_pkg::cell_ctl_type        ctl;
   spq_pkg::entry_type           cell_entry [spq_pkg::QUEUE_DEPTH];
   logic [spq_pkg::QUEUE_DEPTH-1:0] cell_stay;
   logic [spq_pkg::QUEUE_DEPTH-1:0] cell_occ;

   logic accept;
   logic is_full;
   logic is_empty;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_full      = (count_ff == spq_pkg::CNT_BITS'(spq_pkg::QUEUE_DEPTH));
   assign is_empty     = (count_ff == '0);

   always_comb begin
      ctl.ins       = accept && (req_if.word.req_type == spq_pkg::REQ_INSERT) && !is_full;
      ctl.pop       = accept && (req_if.word.req_type == spq_pkg::REQ_POP) && !is_empty;
      ctl.fresh.id  = req_if.word.entry_id;
      ctl.fresh.key = req_if.word.entry_key;
   end

   for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (spq_pkg::CNT_BITS'(i) < count_ff);
      if (i == 0) begin : g_head
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occ         (cell_occ[i]),
            .left_stay   (1'b1),
            .left_entry  (ctl.fresh),
            .right_entry (cell_entry[(i + 1) % spq_pkg::QUEUE_DEPTH]),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
         );
      end else if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_tail
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occ         (cell_occ[i]),
            .left_stay   (cell_stay[i-1]),
            .left_entry  (cell_entry[i-1]),
            .right_entry (cell_entry[i]),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
         );
      end else begin : g_mid
         spq_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .occ         (cell_occ[i]),
            .left_stay   (cell_stay[i-1]),
            .left_entry  (cell_entry[i-1]),
            .right_entry (cell_entry[i+1]),
            .entry       (cell_entry[i]),
            .stay        (cell_stay[i])
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end

      rsp_word_in              = '0;
      rsp_word_in.occupancy    = spq_pkg::OCC_BITS'(count_in);
      rsp_word_in.popped_valid = ctl.pop;
      if (ctl.pop) begin
         rsp_word_in.popped_id  = cell_entry[0].id;
         rsp_word_in.popped_key = cell_entry[0].key;
      end
      if (req_if.word.req_type == spq_pkg::REQ_POP) begin
         rsp_word_in.status = is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
      end else begin
         rsp_word_in.status = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_BITS'(spq_pkg::QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.ins |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the queue");

   a_empty_stays: assert property (@(posedge clock) disable iff (reset)
      accept && is_empty && req_if.word.req_type == spq_pkg::REQ_POP |=> count_ff == '0)
      else $error("pop on empty queue changed occupancy");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.popped_valid |-> rsp_word_ff.status == spq_pkg::ST_OK)
      else $error("popped word with error status");

endmodule
